/* rtl/glyph_bbox_normalize_core_defines.svh */
// assertion macros for the glyph bbox normalize core checker
// no dependencies; clk and rst are taken from the scope of use
`ifndef GLYPH_BBOX_NORMALIZE_CORE_DEFINES_SVH
`define GLYPH_BBOX_NORMALIZE_CORE_DEFINES_SVH

// same-cycle implication
`define GBN_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gbn check failed");

// next-cycle implication
`define GBN_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gbn check failed");

`endif

/* rtl/gbn_pkg.sv */
// shared types, constants and helpers for the glyph bbox normalize core
// no dependencies
package gbn_pkg;

  localparam int MAX_SRC_SIDE = 64;
  localparam int MAX_OUT_SIDE = 32;
  localparam int SRC_IDX_W    = $clog2(MAX_SRC_SIDE);
  localparam int SIDE_W       = SRC_IDX_W + 1;
  localparam int OUT_IDX_W    = $clog2(MAX_OUT_SIDE);
  localparam int OSZ_W        = OUT_IDX_W + 1;
  localparam int ADDR_W       = 2 * SRC_IDX_W;
  localparam int STORE_DEPTH  = MAX_SRC_SIDE * MAX_SRC_SIDE;
  localparam int PROD_W       = OUT_IDX_W + SIDE_W;
  localparam int DIV_STEPS    = SRC_IDX_W;
  localparam int CNT_W        = $clog2(DIV_STEPS);

  localparam logic [7:0] WHITE = 8'hFF;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_READ = 1'b1;

  localparam logic [1:0] REG_SRC_WIDTH  = 2'd0;
  localparam logic [1:0] REG_SRC_HEIGHT = 2'd1;
  localparam logic [1:0] REG_OUT_SIZE   = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_CALC = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_ADDR = 5'b01000,
    ST_OUT  = 5'b10000
  } gbn_state_t;

  function automatic logic [SIDE_W-1:0] clamp_src(input logic [6:0] v);
    logic [SIDE_W-1:0] r;
    if (v == 7'd0) begin
      r = SIDE_W'(1);
    end else if (v > 7'(MAX_SRC_SIDE)) begin
      r = SIDE_W'(MAX_SRC_SIDE);
    end else begin
      r = SIDE_W'(v);
    end
    return r;
  endfunction

  function automatic logic [OSZ_W-1:0] clamp_out(input logic [5:0] v);
    logic [OSZ_W-1:0] r;
    if (v == 6'd0) begin
      r = OSZ_W'(1);
    end else if (v > 6'(MAX_OUT_SIDE)) begin
      r = OSZ_W'(MAX_OUT_SIDE);
    end else begin
      r = OSZ_W'(v);
    end
    return r;
  endfunction

endpackage

/* rtl/glyph_bbox_normalize_core.sv */
// glyph bbox normalize core: image store, bounding box tracking and scaled readout
// depends on gbn_pkg
//
// Source pixels arrive as load transfers (tuser 0) in raster order and are written
// into a 64x64 byte store while the bounding box of non-white pixels is tracked; a
// load at position (0,0) starts a new frame. A read transfer (tuser 1) returns the
// pixel at (out_col,out_row) of the box padded to a centered white square and
// resized by nearest neighbor to out_size x out_size. Loads stream at full rate
// while no read is in progress. A read goes from transfer to result in steps:
// sizing the box and forming the two products, the shared-divisor restoring
// divider that scales both coordinates by 1/out_size, the store read and the
// fill of the output register. A read of a blank image skips the divider and
// the store read. The input reopens as the output register fills, so a new read
// is taken only once the last one is through, and is held off further while a
// stalled earlier result holds the output register. The output register lets a
// new transfer in while a result waits. Writing src_width or src_height restarts
// the load position.
module glyph_bbox_normalize_core import gbn_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // pixel[7:0], out_col[12:8], out_row[17:13], zeros
  input  logic        s_tuser,   // mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // out_pixel[7:0], box_side[14:8], zero
  output logic        m_tuser    // blank_image
);

  gbn_state_t state;

  logic [6:0] src_width;
  logic [6:0] src_height;
  logic [5:0] out_size;

  logic [SRC_IDX_W-1:0] load_col, load_row;
  logic [SRC_IDX_W-1:0] box_left, box_right, box_top, box_bottom;
  logic                 dark_seen;

  logic [7:0] store [STORE_DEPTH];
  logic [7:0] rd_data;

  logic [OUT_IDX_W-1:0] rd_col, rd_row;
  logic                 blank;
  logic [SIDE_W-1:0]    side_r, bw_r, bh_r;
  logic [SRC_IDX_W-1:0] xo_r, yo_r;
  logic [OSZ_W-1:0]     osz_r;
  logic                 in_range;
  logic [OSZ_W-1:0]     rem_x, rem_y;
  logic [SRC_IDX_W-1:0] dq_x, dq_y;
  logic [CNT_W-1:0]     step_cnt;
  logic                 hit_r;

  logic [7:0]        out_pix;
  logic [SIDE_W-1:0] out_side;
  logic              out_blank;

  logic       cfg_wr;
  logic [1:0] cfg_idx;
  logic       s_acc, load_acc, read_acc, out_ready;

  logic [7:0]           in_pixel;
  logic [OUT_IDX_W-1:0] in_col, in_row;

  logic                 frame_start, dark_now, is_dark;
  logic [SIDE_W-1:0]    width_c, height_c, col_p1, row_p1;

  logic [SIDE_W-1:0]    bw, bh, side;
  logic [SRC_IDX_W-1:0] xo, yo;
  logic [OSZ_W-1:0]     osz;
  logic [PROD_W-1:0]    prod_x, prod_y;

  logic [OSZ_W-1:0]     rem_x_next, rem_y_next;
  logic                 qx, qy;

  logic [SIDE_W-1:0]    sx, sy, xo_e, yo_e, src_c, src_r;
  logic                 hit;
  logic [ADDR_W-1:0]    rd_addr;

  function automatic logic [OSZ_W:0] div_step(input logic [OSZ_W-1:0] rem,
                                               input logic nbit,
                                               input logic [OSZ_W-1:0] dvs);
    logic [OSZ_W:0] trial;
    logic [OSZ_W:0] res;
    trial = {rem, nbit};
    if (trial >= {1'b0, dvs}) begin
      res = {OSZ_W'(trial - {1'b0, dvs}), 1'b1};
    end else begin
      res = {OSZ_W'(trial), 1'b0};
    end
    return res;
  endfunction

  // config port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[3:2];

  always_comb begin
    case (cfg_idx)
      REG_SRC_WIDTH:  prdata = 32'(src_width);
      REG_SRC_HEIGHT: prdata = 32'(src_height);
      REG_OUT_SIZE:   prdata = 32'(out_size);
      default:        prdata = 32'd0;
    endcase
  end

  // stream side
  assign s_tready  = (state == ST_IDLE);
  assign s_acc     = s_tvalid && s_tready;
  assign load_acc  = s_acc && (s_tuser == MODE_LOAD);
  assign read_acc  = s_acc && (s_tuser == MODE_READ);
  assign out_ready = !m_tvalid || m_tready;

  assign in_pixel = s_tdata[7:0];
  assign in_col   = s_tdata[12:8];
  assign in_row   = s_tdata[17:13];

  assign m_tdata = {1'b0, out_side, out_pix};
  assign m_tuser = out_blank;

  // load path
  assign frame_start = (load_col == '0) && (load_row == '0);
  assign dark_now    = dark_seen && !frame_start;
  assign is_dark     = (in_pixel != WHITE);
  assign width_c     = clamp_src(src_width);
  assign height_c    = clamp_src(src_height);
  assign col_p1      = {1'b0, load_col} + SIDE_W'(1);
  assign row_p1      = {1'b0, load_row} + SIDE_W'(1);

  // box geometry
  assign bw   = {1'b0, box_right} - {1'b0, box_left} + SIDE_W'(1);
  assign bh   = {1'b0, box_bottom} - {1'b0, box_top} + SIDE_W'(1);
  assign side = (bw > bh) ? bw : bh;
  assign xo   = SRC_IDX_W'((side - bw) >> 1);
  assign yo   = SRC_IDX_W'((side - bh) >> 1);
  assign osz  = clamp_out(out_size);
  assign prod_x = PROD_W'(rd_col) * PROD_W'(side);
  assign prod_y = PROD_W'(rd_row) * PROD_W'(side);

  // divider step
  assign {rem_x_next, qx} = div_step(rem_x, dq_x[SRC_IDX_W-1], osz_r);
  assign {rem_y_next, qy} = div_step(rem_y, dq_y[SRC_IDX_W-1], osz_r);

  // source address
  assign sx    = {1'b0, dq_x};
  assign sy    = {1'b0, dq_y};
  assign xo_e  = {1'b0, xo_r};
  assign yo_e  = {1'b0, yo_r};
  assign src_c = {1'b0, box_left} + (sx - xo_e);
  assign src_r = {1'b0, box_top} + (sy - yo_e);
  assign hit   = in_range && (sx >= xo_e) && (sx < xo_e + bw_r) &&
                 (sy >= yo_e) && (sy < yo_e + bh_r) &&
                 (src_c < SIDE_W'(MAX_SRC_SIDE)) && (src_r < SIDE_W'(MAX_SRC_SIDE));
  assign rd_addr = {src_r[SRC_IDX_W-1:0], src_c[SRC_IDX_W-1:0]};

  // image store
  always_ff @(posedge clk) begin
    if (load_acc) begin
      store[{load_row, load_col}] <= in_pixel;
    end
    if (state == ST_ADDR) begin
      rd_data <= store[rd_addr];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      src_width  <= 7'(MAX_SRC_SIDE);
      src_height <= 7'(MAX_SRC_SIDE);
      out_size   <= 6'd20;
      load_col   <= '0;
      load_row   <= '0;
      box_left   <= '0;
      box_right  <= '0;
      box_top    <= '0;
      box_bottom <= '0;
      dark_seen  <= 1'b0;
      step_cnt   <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (load_acc) begin
        if (is_dark) begin
          if (!dark_now) begin
            box_left   <= load_col;
            box_right  <= load_col;
            box_top    <= load_row;
            box_bottom <= load_row;
          end else begin
            if (load_col < box_left)   box_left   <= load_col;
            if (load_col > box_right)  box_right  <= load_col;
            if (load_row < box_top)    box_top    <= load_row;
            if (load_row > box_bottom) box_bottom <= load_row;
          end
        end
        dark_seen <= dark_now || is_dark;
        if (col_p1 >= width_c) begin
          load_col <= '0;
          load_row <= (row_p1 >= height_c) ? '0 : row_p1[SRC_IDX_W-1:0];
        end else begin
          load_col <= col_p1[SRC_IDX_W-1:0];
        end
      end

      if (cfg_wr) begin
        case (cfg_idx)
          REG_SRC_WIDTH: begin
            src_width <= pwdata[6:0];
            load_col  <= '0;
            load_row  <= '0;
          end
          REG_SRC_HEIGHT: begin
            src_height <= pwdata[6:0];
            load_col   <= '0;
            load_row   <= '0;
          end
          REG_OUT_SIZE: begin
            out_size <= pwdata[5:0];
          end
          default: begin
          end
        endcase
      end

      if (state == ST_OUT && out_ready) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (read_acc) state <= ST_CALC;
        end
        ST_CALC: begin
          step_cnt <= '0;
          state    <= dark_seen ? ST_DIV : ST_OUT;
        end
        ST_DIV: begin
          step_cnt <= step_cnt + CNT_W'(1);
          if (step_cnt == CNT_W'(DIV_STEPS - 1)) state <= ST_ADDR;
        end
        ST_ADDR: begin
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (out_ready) state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // read datapath
  always_ff @(posedge clk) begin
    if (read_acc) begin
      rd_col <= in_col;
      rd_row <= in_row;
    end
    if (state == ST_CALC) begin
      blank    <= !dark_seen;
      side_r   <= side;
      bw_r     <= bw;
      bh_r     <= bh;
      xo_r     <= xo;
      yo_r     <= yo;
      osz_r    <= osz;
      in_range <= (OSZ_W'(rd_col) < osz) && (OSZ_W'(rd_row) < osz);
      rem_x    <= prod_x[PROD_W-1:SRC_IDX_W];
      rem_y    <= prod_y[PROD_W-1:SRC_IDX_W];
      dq_x     <= prod_x[SRC_IDX_W-1:0];
      dq_y     <= prod_y[SRC_IDX_W-1:0];
    end
    if (state == ST_DIV) begin
      rem_x <= rem_x_next;
      rem_y <= rem_y_next;
      dq_x  <= {dq_x[SRC_IDX_W-2:0], qx};
      dq_y  <= {dq_y[SRC_IDX_W-2:0], qy};
    end
    if (state == ST_ADDR) begin
      hit_r <= hit;
    end
    if (state == ST_OUT && out_ready) begin
      out_blank <= blank;
      out_side  <= blank ? '0 : side_r;
      out_pix   <= (!blank && hit_r) ? rd_data : WHITE;
    end
  end

endmodule

/* rtl/gbn_checker.sv */
// port-level checks for the glyph bbox normalize core, bound to the top level
// depends on gbn_pkg and glyph_bbox_normalize_core_defines.svh
`include "glyph_bbox_normalize_core_defines.svh"

module gbn_checker import gbn_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tuser
);

  // blank result is white with no box
  `GBN_ASSERT_IMPL(a_blank_white, m_tvalid && m_tuser, m_tdata[14:0] == {7'd0, WHITE})

  // square side never exceeds the source side
  `GBN_ASSERT_IMPL(a_side_max, m_tvalid, m_tdata[14:8] <= 7'(MAX_SRC_SIDE))

  // a read transfer keeps the input closed while it works
  `GBN_ASSERT_NEXT(a_read_busy, s_tvalid && s_tready && (s_tuser == MODE_READ), !s_tready)

  // a load transfer leaves the input open
  `GBN_ASSERT_NEXT(a_load_fast, s_tvalid && s_tready && (s_tuser == MODE_LOAD), s_tready)

  // stalled result holds
  `GBN_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

bind glyph_bbox_normalize_core gbn_checker u_gbn_checker (.*);

/* sim/testbench.sv */
`timescale 1ns / 100ps
// testbench for glyph_bbox_normalize_core: loads small frames and reads back the
// scaled glyph square over the stream ports, comparing against an in-bench predictor
// depends on gbn_pkg and the core; register setup goes through the apb port
module testbench;
  import gbn_pkg::*;

  typedef struct packed {
    logic [7:0] pixel;
    logic       blank;
    logic [6:0] side;
  } glyph_result_t;

  class glyph_scoreboard;
    logic [7:0]     pixels [STORE_DEPTH];
    bit             loaded [STORE_DEPTH];
    int unsigned    load_col, load_row;
    int unsigned    box_l, box_r, box_t, box_b;
    bit             dark_seen;
    int unsigned    reg_w, reg_h, reg_osz;
    glyph_result_t  awaited[$];
    int unsigned    mismatches;

    function new();
      foreach (pixels[i]) begin
        pixels[i] = 8'd0;
        loaded[i] = 1'b0;
      end
      load_col = 0;
      load_row = 0;
      box_l = 0;
      box_r = 0;
      box_t = 0;
      box_b = 0;
      dark_seen = 1'b0;
      reg_w = 64;
      reg_h = 64;
      reg_osz = 20;
      mismatches = 0;
    endfunction

    function int unsigned clamp(int unsigned v, int unsigned hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    function void write_reg(logic [1:0] idx, int unsigned v);
      case (idx)
        REG_SRC_WIDTH: begin
          reg_w = v & 'h7f;
          load_col = 0;
          load_row = 0;
        end
        REG_SRC_HEIGHT: begin
          reg_h = v & 'h7f;
          load_col = 0;
          load_row = 0;
        end
        REG_OUT_SIZE: begin
          reg_osz = v & 'h3f;
        end
        default: ;
      endcase
    endfunction

    // returns 1 when the read would hit a store entry never written
    function bit scale(input int unsigned col, input int unsigned row,
                       output glyph_result_t res);
      int unsigned osz, bw, bh, side, xo, yo, sx, sy, addr;
      bit hole;
      hole = 1'b0;
      if (!dark_seen) begin
        res = '{pixel: WHITE, blank: 1'b1, side: 7'd0};
        return hole;
      end
      osz = clamp(reg_osz, MAX_OUT_SIDE);
      bw = box_r - box_l + 1;
      bh = box_b - box_t + 1;
      side = (bw > bh) ? bw : bh;
      xo = (side - bw) / 2;
      yo = (side - bh) / 2;
      res.pixel = WHITE;
      if (col < osz && row < osz) begin
        sx = col * side / osz;
        sy = row * side / osz;
        if (sx >= xo && sx < xo + bw && sy >= yo && sy < yo + bh) begin
          addr = (box_t + sy - yo) * MAX_SRC_SIDE + (box_l + sx - xo);
          hole = !loaded[addr];
          res.pixel = pixels[addr];
        end
      end
      res.blank = 1'b0;
      res.side = 7'(side);
      return hole;
    endfunction

    function void note_input(logic mode, logic [7:0] pix, logic [4:0] col, logic [4:0] row);
      glyph_result_t res;
      int unsigned w, h, addr;
      if (mode == MODE_READ) begin
        void'(scale(col, row, res));
        awaited.push_back(res);
        return;
      end
      w = clamp(reg_w, MAX_SRC_SIDE);
      h = clamp(reg_h, MAX_SRC_SIDE);
      if (load_col == 0 && load_row == 0) dark_seen = 1'b0;
      addr = load_row * MAX_SRC_SIDE + load_col;
      pixels[addr] = pix;
      loaded[addr] = 1'b1;
      if (pix != WHITE) begin
        if (!dark_seen) begin
          box_l = load_col;
          box_r = load_col;
          box_t = load_row;
          box_b = load_row;
          dark_seen = 1'b1;
        end else begin
          if (load_col < box_l) box_l = load_col;
          if (load_col > box_r) box_r = load_col;
          if (load_row < box_t) box_t = load_row;
          if (load_row > box_b) box_b = load_row;
        end
      end
      if (load_col + 1 >= w) begin
        load_col = 0;
        load_row = (load_row + 1 >= h) ? 0 : load_row + 1;
      end else begin
        load_col = load_col + 1;
      end
    endfunction

    function void check_result(glyph_result_t got);
      glyph_result_t want;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: pixel %0d blank %0d side %0d",
                   got.pixel, got.blank, got.side);
        return;
      end
      want = awaited.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch pixel/blank/side: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                   want.pixel, want.blank, want.side, got.pixel, got.blank, got.side);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = 4'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = 24'd0;  // pixel[7:0], out_col[12:8], out_row[17:13], zeros
  logic        s_tuser = 1'b0;   // mode
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;          // out_pixel[7:0], box_side[14:8], zero
  logic        m_tuser;          // blank_image

  glyph_scoreboard sb;
  int unsigned tx_idle = 0;
  int unsigned rx_stall = 0;
  int unsigned sent_items = 0;

  int unsigned cfg_w   [12] = '{5, 1, 64, 1,  0, 127, 12, 7,  64, 16, 3,  10};
  int unsigned cfg_h   [12] = '{4, 1, 1,  64, 0, 2,   9,  13, 64, 16, 8,  10};
  int unsigned cfg_osz [12] = '{8, 1, 32, 20, 0, 63,  32, 3,  32, 17, 31, 5};

  glyph_bbox_normalize_core dut (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(20_000_000);
    $display("TEST FAILED");
    $finish;
  end

  always @(posedge clk) m_tready <= ($urandom_range(99) >= rx_stall);

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_result(glyph_result_t'({m_tdata[7:0], m_tuser, m_tdata[14:8]}));
  end

  task automatic send_item(logic mode, logic [7:0] pix, logic [4:0] col, logic [4:0] row);
    while ($urandom_range(99) < tx_idle) begin
      s_tvalid <= 1'b0;
      s_tdata <= 24'($urandom);
      s_tuser <= 1'($urandom);
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {6'd0, row, col, pix};
    s_tuser <= mode;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_input(mode, pix, col, row);
    sent_items++;
  endtask

  task automatic load_pixel(logic [7:0] pix);
    send_item(MODE_LOAD, pix, 5'($urandom), 5'($urandom));
  endtask

  task automatic read_pixel(logic [4:0] col, logic [4:0] row);
    send_item(MODE_READ, 8'($urandom), col, row);
  endtask

  task automatic write_reg(logic [1:0] idx, int unsigned v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.write_reg(idx, v);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    int unsigned waited;
    waited = 0;
    s_tvalid <= 1'b0;
    while (sb.awaited.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (16) @(posedge clk);
  endtask

  // loads up to the end of the current frame, dark pixels inside a random rectangle
  task automatic load_frame(int unsigned limit);
    int unsigned w, h, x0, x1, y0, y1, n, dark_pct;
    logic [7:0] pix;
    w = sb.clamp(sb.reg_w, MAX_SRC_SIDE);
    h = sb.clamp(sb.reg_h, MAX_SRC_SIDE);
    x0 = $urandom_range(w - 1);
    x1 = $urandom_range(w - 1, x0);
    y0 = $urandom_range(h - 1);
    y1 = $urandom_range(h - 1, y0);
    dark_pct = ($urandom_range(9) == 0) ? 0 : $urandom_range(100, 30);
    n = 0;
    do begin
      if (sb.load_col >= x0 && sb.load_col <= x1 && sb.load_row >= y0 &&
          sb.load_row <= y1 && $urandom_range(99) < dark_pct)
        pix = 8'($urandom_range(254));
      else
        pix = WHITE;
      load_pixel(pix);
      n++;
    end while (!(sb.load_col == 0 && sb.load_row == 0) && n < limit);
  endtask

  task automatic read_burst(int unsigned n);
    int unsigned osz, col, row, tries;
    glyph_result_t res;
    repeat (n) begin
      osz = sb.clamp(sb.reg_osz, MAX_OUT_SIDE);
      for (tries = 0; tries < 8; tries++) begin
        if ($urandom_range(9) == 0) begin
          col = $urandom_range(31);
          row = $urandom_range(31);
        end else begin
          col = $urandom_range(osz - 1);
          row = $urandom_range(osz - 1);
        end
        if (!sb.scale(col, row, res)) break;
      end
      if (tries < 8) read_pixel(5'(col), 5'(row));
    end
  endtask

  task automatic run_phase(int unsigned idx, int unsigned budget);
    int unsigned start, area, choice, p_tx, p_rx;
    write_reg(REG_SRC_WIDTH, cfg_w[idx]);
    write_reg(REG_SRC_HEIGHT, cfg_h[idx]);
    write_reg(REG_OUT_SIZE, cfg_osz[idx]);
    case (idx % 4)
      0: begin p_tx = 0;  p_rx = 0;  end
      1: begin p_tx = 75; p_rx = 0;  end
      2: begin p_tx = 0;  p_rx = 75; end
      default: begin p_tx = 19; p_rx = 19; end
    endcase
    area = sb.clamp(sb.reg_w, MAX_SRC_SIDE) * sb.clamp(sb.reg_h, MAX_SRC_SIDE);
    start = sent_items;
    while (sent_items - start < budget) begin
      if ($urandom_range(3) == 0) begin
        tx_idle = 0;
        rx_stall = 0;
      end else begin
        tx_idle = p_tx;
        rx_stall = p_rx;
      end
      choice = $urandom_range(99);
      if (choice < 65 && area <= 200) begin
        load_frame(area);
        read_burst($urandom_range(10, 3));
      end else if (choice < 85) begin
        load_frame($urandom_range((area < 150) ? area : 150, 1));
        read_burst($urandom_range(6, 1));
      end else begin
        // noise: loose mix of loads and reads
        repeat ($urandom_range(8, 2)) begin
          if ($urandom_range(1) == 0) load_pixel(8'($urandom));
          else read_burst(1);
        end
      end
    end
    drain();
  endtask

  initial begin
    sb = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // blank store after reset
    read_pixel(5'd0, 5'd0);
    read_pixel(5'd31, 5'd31);
    drain();
    write_reg(REG_SRC_WIDTH, 3);
    write_reg(REG_SRC_HEIGHT, 2);
    write_reg(REG_OUT_SIZE, 4);
    // 3x2 box, padded to side 3 with a white bottom row
    load_pixel(8'd0);
    repeat (4) load_pixel(WHITE);
    load_pixel(8'd254);
    read_pixel(5'd0, 5'd0);
    read_pixel(5'd3, 5'd3);
    read_pixel(5'd2, 5'd1);
    read_pixel(5'd31, 5'd0);
    read_pixel(5'd0, 5'd31);
    // all white frame
    repeat (6) load_pixel(WHITE);
    read_pixel(5'd1, 5'd1);
    // read in the middle of a frame with a single dark pixel
    load_pixel(WHITE);
    load_pixel(8'h80);
    read_pixel(5'd2, 5'd2);
    drain();

    for (int i = 0; i < 12; i++) run_phase(i, 30);

    tx_idle = 0;
    rx_stall = 0;
    drain();
    if (sb.mismatches == 0 && sb.awaited.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

/* glyph_bbox_normalize_core.f */
+incdir+rtl
rtl/gbn_pkg.sv
rtl/glyph_bbox_normalize_core.sv
rtl/gbn_checker.sv
sim/testbench.sv
